// ----- src/cdt_pkg.sv -----
// ----------------------------------------------------------------------------
// cdt_pkg: shared definitions for the TSC charge deposition block
// Grid geometry, store layout, codes, handshake structs and address helpers.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int CELLS_X = 16;
    localparam int CELLS_Y = 16;
    localparam int CELLS_Z = 16;
    localparam int GHOST   = 1;
    localparam int PLANES  = 3;

    localparam int DIM_X = CELLS_X + 2 * GHOST;
    localparam int DIM_Y = CELLS_Y + 2 * GHOST;
    localparam int DIM_Z = CELLS_Z + 2 * GHOST;
    localparam int DIM_XY  = (DIM_X > DIM_Y) ? DIM_X : DIM_Y;
    localparam int DIM_MAX = (DIM_XY > DIM_Z) ? DIM_XY : DIM_Z;
    localparam int IDX_W   = $clog2(DIM_MAX);

    localparam int STORE_SIZE = PLANES * DIM_X * DIM_Y * DIM_Z;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCED  = 3'd7;

    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_DEPOSIT = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [1:0] PLANE_ELEC = 2'd0;
    localparam logic [1:0] PLANE_ION  = 2'd1;
    localparam logic [1:0] PLANE_NEUT = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic [16:0]        wgt_t;
    typedef logic signed [25:0] cell_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         tag;
        logic               red;
        logic signed [32:0] diff;
        logic [23:0]        inv;
    } axis_req_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] tag;
        cell_t      cpos;
        wgt_t       wm;
        wgt_t       w0;
        wgt_t       wp;
    } axis_res_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [1:0] p,
                                                    input logic [IDX_W-1:0] z,
                                                    input logic [IDX_W-1:0] y,
                                                    input logic [IDX_W-1:0] x);
        return ADDR_W'(((int'(p) * DIM_Z + int'(z)) * DIM_Y + int'(y)) * DIM_X + int'(x));
    endfunction

    function automatic wgt_t wsel(input logic [1:0] k, input wgt_t a, input wgt_t b,
                                  input wgt_t c);
        wgt_t r;
        case (k)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ----- src/cdt_ram.sv -----
// ----------------------------------------------------------------------------
// cdt_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/cdt_axis.sv -----
// ----------------------------------------------------------------------------
// cdt_axis: per-axis cell and quadratic weight unit
// Three-stage pipeline: scaled offset, nearest cell, TSC weights.
// ----------------------------------------------------------------------------
module cdt_axis (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdt_pkg::axis_req_t   req,
    output cdt_pkg::axis_res_t   res
);
    import cdt_pkg::*;

    logic               s1_v_reg;
    logic [1:0]         s1_tag_reg;
    logic               s1_red_reg;
    logic signed [45:0] s1_pl_reg;
    logic signed [45:0] s1_ph_reg;
    logic               s2_v_reg;
    logic [1:0]         s2_tag_reg;
    logic               s2_red_reg;
    cell_t              s2_j_reg;
    logic [15:0]        s2_r_reg;
    logic               res_v_reg;
    logic [1:0]         res_tag_reg;
    cell_t              res_cpos_reg;
    wgt_t               res_wm_reg;
    wgt_t               res_w0_reg;
    wgt_t               res_wp_reg;

    logic signed [45:0] pl;
    logic signed [45:0] ph;
    logic signed [57:0] prod;
    logic signed [42:0] usum;
    logic [16:0]        a;
    logic [33:0]        aa;
    logic [31:0]        bb;
    logic signed [17:0] h;
    logic signed [35:0] hh;

    assign pl   = req.diff * $signed({1'b0, req.inv[11:0]});
    assign ph   = req.diff * $signed({1'b0, req.inv[23:12]});
    assign prod = (s1_ph_reg <<< 12) + s1_pl_reg;
    assign usum = $signed(prod[57:16]) + 43'sd32768;
    assign a    = 17'd65536 - {1'b0, s2_r_reg};
    assign aa   = a * a;
    assign bb   = s2_r_reg * s2_r_reg;
    assign h    = $signed(18'd32768 - {2'b0, s2_r_reg});
    assign hh   = h * h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= req.valid;
            s2_v_reg  <= s1_v_reg;
            res_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= req.tag;
        s1_red_reg  <= req.red;
        s1_pl_reg   <= pl;
        s1_ph_reg   <= ph;
        s2_tag_reg  <= s1_tag_reg;
        s2_red_reg  <= s1_red_reg;
        s2_j_reg    <= usum[41:16];
        s2_r_reg    <= usum[15:0];
        res_tag_reg <= s2_tag_reg;
        if (s2_red_reg)
        begin
            res_cpos_reg <= '0;
            res_wm_reg   <= '0;
            res_w0_reg   <= 17'd65536;
            res_wp_reg   <= '0;
        end
        else
        begin
            res_cpos_reg <= s2_j_reg;
            res_wm_reg   <= aa[33:17];
            res_w0_reg   <= 17'd49152 - {1'b0, hh[31:16]};
            res_wp_reg   <= {2'b0, bb[31:17]};
        end
    end

    assign res = {res_v_reg, res_tag_reg, res_cpos_reg, res_wm_reg, res_w0_reg, res_wp_reg};

endmodule

// ----- src/charge_density_deposit_tsc.sv -----
// ----------------------------------------------------------------------------
// charge_density_deposit_tsc: TSC charge deposition into a density store
// Scatters particles over a 27-cell stencil with saturating accumulation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; func selects clear,
// deposit or read. Each item gives one result, shown for one cycle with done
// high on cell_value, dropped and saturated; the receiver cannot stall it.
// The store lives in one dual-port RAM, one word per cell and plane.
// A deposit keeps busy high through setup (three axis requests through
// one three-stage weight pipe), one stencil cell per cycle (27, or fewer with
// reduced axes) and the read-modify-write drain; its result follows in the
// next cycle after the drain. The single RAM port pair sets the per-cell pace.
// A read item goes through a RAM read state and a capture state before its
// result. An unused func code answers straight from idle.
// A clear item sweeps every RAM word (17496 at the default sizes) and
// answers in the cycle after the sweep.
// After reset the same sweep runs with busy high; it produces no result.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module charge_density_deposit_tsc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic [1:0]                   func,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic signed [15:0]           charge,
    input  logic [15:0]                  weight,
    input  logic [1:0]                   read_plane,
    input  logic [4:0]                   read_x,
    input  logic [4:0]                   read_y,
    input  logic [4:0]                   read_z,
    output logic signed [31:0]           cell_value,
    output logic                         dropped,
    output logic                         saturated,
    input  logic                         cfg_we,
    input  logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0]    cfg_data
);
    import cdt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_CELL  = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_RD0   = 7'b0100000,
        ST_RD1   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              clr_item_reg, clr_item_next;
    logic              done_reg, done_next;
    logic signed [31:0] value_reg, value_next;
    logic              drop_reg, drop_next;
    logic              sat_reg, sat_next;
    logic              rd_ok_reg, rd_ok_next;

    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [23:0]        inv_x_reg, inv_y_reg, inv_z_reg, scale_reg;
    logic [2:0]         red_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] charge_reg;
    logic [15:0]        weight_reg;
    logic [1:0]         rplane_reg;
    logic [4:0]         rx_reg, ry_reg, rz_reg;

    logic signed [32:0] qw_reg;
    logic signed [41:0] fnq_reg;
    logic [1:0]         plane_reg;
    cell_t              jx_reg, jy_reg, jz_reg;
    wgt_t               wxm_reg, wx0_reg, wxp_reg;
    wgt_t               wym_reg, wy0_reg, wyp_reg;
    wgt_t               wzm_reg, wz0_reg, wzp_reg;

    logic               p1_v_reg, p2_v_reg, p3_v_reg;
    logic [ADDR_W-1:0]  p1_addr_reg, p2_addr_reg, p3_addr_reg;
    logic [17:0]        p1_wxy_reg;
    wgt_t               p1_wz_reg;
    logic [18:0]        p2_wxyz_reg;
    logic signed [31:0] p2_old_reg, p3_old_reg;
    logic signed [45:0] p3_contrib_reg;

    axis_req_t          ax_req;
    axis_res_t          ax_res;

    logic signed [31:0] pos_sel, org_sel;
    logic signed [32:0] qw;
    logic signed [57:0] fnq_full;
    logic signed [26:0] sx, sy, sz;
    logic               inr;
    logic [ADDR_W-1:0]  cell_a;
    logic [33:0]        m1;
    logic [34:0]        m2;
    logic signed [61:0] m3;
    logic signed [46:0] sum;
    logic signed [31:0] sum_sat;
    logic               sum_clip;
    logic [1:0]         kx0, ky0, kz0, kxe, kye, kze;
    logic               rd_inr;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, ram_rdata;

    cdt_axis u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ax_req),
        .res   (ax_res)
    );

    cdt_ram #(
        .DEPTH (STORE_SIZE),
        .WIDTH (32)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign kx0 = red_reg[0] ? 2'd1 : 2'd0;
    assign ky0 = red_reg[1] ? 2'd1 : 2'd0;
    assign kz0 = red_reg[2] ? 2'd1 : 2'd0;
    assign kxe = red_reg[0] ? 2'd1 : 2'd2;
    assign kye = red_reg[1] ? 2'd1 : 2'd2;
    assign kze = red_reg[2] ? 2'd1 : 2'd2;

    always_comb
    begin
        case (cnt_reg)
            AXIS_X:
            begin
                pos_sel = px_reg;
                org_sel = org_x_reg;
                ax_req.inv = inv_x_reg;
            end
            AXIS_Y:
            begin
                pos_sel = py_reg;
                org_sel = org_y_reg;
                ax_req.inv = inv_y_reg;
            end
            default:
            begin
                pos_sel = pz_reg;
                org_sel = org_z_reg;
                ax_req.inv = inv_z_reg;
            end
        endcase
        ax_req.valid = (state_reg == ST_SETUP) && (cnt_reg != 2'd3);
        ax_req.tag   = cnt_reg;
        ax_req.red   = red_reg[cnt_reg];
        ax_req.diff  = $signed({pos_sel[31], pos_sel}) - $signed({org_sel[31], org_sel});
    end

    assign qw = (charge_reg == 16'sd0) ? $signed({9'd0, weight_reg, 8'd0})
                                       : charge_reg * $signed({1'b0, weight_reg});
    assign fnq_full = qw_reg * $signed({1'b0, scale_reg});

    assign sx = $signed({jx_reg[25], jx_reg}) + $signed({25'd0, kx_reg}) + 27'(GHOST - 1);
    assign sy = $signed({jy_reg[25], jy_reg}) + $signed({25'd0, ky_reg}) + 27'(GHOST - 1);
    assign sz = $signed({jz_reg[25], jz_reg}) + $signed({25'd0, kz_reg}) + 27'(GHOST - 1);
    assign inr = (sx >= 27'sd0) && (sx < 27'(DIM_X)) && (sy >= 27'sd0) &&
                 (sy < 27'(DIM_Y)) && (sz >= 27'sd0) && (sz < 27'(DIM_Z));
    assign cell_a = cell_addr(plane_reg, sz[IDX_W-1:0], sy[IDX_W-1:0], sx[IDX_W-1:0]);

    assign m1 = wsel(kx_reg, wxm_reg, wx0_reg, wxp_reg) *
                wsel(ky_reg, wym_reg, wy0_reg, wyp_reg);
    assign m2 = p1_wxy_reg * p1_wz_reg;
    assign m3 = fnq_reg * $signed({1'b0, p2_wxyz_reg});
    assign sum = $signed({{15{p3_old_reg[31]}}, p3_old_reg}) +
                 $signed({p3_contrib_reg[45], p3_contrib_reg});

    always_comb
    begin
        sum_clip = 1'b1;
        if (sum > 47'sd2147483647)
        begin
            sum_sat = 32'sh7fffffff;
        end
        else if (sum < -47'sd2147483648)
        begin
            sum_sat = 32'sh80000000;
        end
        else
        begin
            sum_sat  = sum[31:0];
            sum_clip = 1'b0;
        end
    end

    assign rd_inr = (rplane_reg < 2'(PLANES)) && (32'(rx_reg) < 32'(DIM_X)) &&
                    (32'(ry_reg) < 32'(DIM_Y)) && (32'(rz_reg) < 32'(DIM_Z));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = p3_addr_reg;
        ram_wdata = sum_sat;
        ram_re    = 1'b0;
        ram_raddr = cell_a;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (p3_v_reg)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_CELL)
        begin
            ram_re = inr;
        end
        else if (state_reg == ST_RD0)
        begin
            ram_re    = rd_inr;
            ram_raddr = cell_addr(rplane_reg, IDX_W'(rz_reg), IDX_W'(ry_reg), IDX_W'(rx_reg));
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        kz_next       = kz_reg;
        clr_next      = clr_reg;
        clr_item_next = clr_item_reg;
        done_next     = 1'b0;
        value_next    = value_reg;
        drop_next     = drop_reg;
        sat_next      = sat_reg;
        rd_ok_next    = rd_ok_reg;
        if (p3_v_reg && sum_clip)
        begin
            sat_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = '0;
                    drop_next  = 1'b0;
                    sat_next   = 1'b0;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            state_next    = ST_CLEAR;
                            clr_next      = '0;
                            clr_item_next = 1'b1;
                        end
                        FUNC_DEPOSIT:
                        begin
                            state_next = ST_SETUP;
                            cnt_next   = '0;
                        end
                        FUNC_READ:
                        begin
                            state_next = ST_RD0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next    = ST_IDLE;
                    done_next     = clr_item_reg;
                    clr_item_next = 1'b0;
                end
            end
            ST_SETUP:
            begin
                if (cnt_reg != 2'd3)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (ax_res.valid && (ax_res.tag == AXIS_Z))
                begin
                    state_next = ST_CELL;
                    kx_next    = kx0;
                    ky_next    = ky0;
                    kz_next    = kz0;
                end
            end
            ST_CELL:
            begin
                if (!inr)
                begin
                    drop_next = 1'b1;
                end
                if (kx_reg != kxe)
                begin
                    kx_next = kx_reg + 1'b1;
                end
                else
                begin
                    kx_next = kx0;
                    if (ky_reg != kye)
                    begin
                        ky_next = ky_reg + 1'b1;
                    end
                    else
                    begin
                        ky_next = ky0;
                        if (kz_reg != kze)
                        begin
                            kz_next = kz_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!p1_v_reg && !p2_v_reg && !p3_v_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_RD0:
            begin
                rd_ok_next = rd_inr;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                value_next = rd_ok_reg ? $signed(ram_rdata) : 32'sd0;
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            kz_reg       <= '0;
            clr_reg      <= '0;
            clr_item_reg <= 1'b0;
            done_reg     <= 1'b0;
            value_reg    <= '0;
            drop_reg     <= 1'b0;
            sat_reg      <= 1'b0;
            rd_ok_reg    <= 1'b0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            org_z_reg    <= '0;
            inv_x_reg    <= 24'd65536;
            inv_y_reg    <= 24'd65536;
            inv_z_reg    <= 24'd65536;
            scale_reg    <= 24'd65536;
            red_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            kx_reg       <= kx_next;
            ky_reg       <= ky_next;
            kz_reg       <= kz_next;
            clr_reg      <= clr_next;
            clr_item_reg <= clr_item_next;
            done_reg     <= done_next;
            value_reg    <= value_next;
            drop_reg     <= drop_next;
            sat_reg      <= sat_next;
            rd_ok_reg    <= rd_ok_next;
            p1_v_reg     <= (state_reg == ST_CELL) && inr;
            p2_v_reg     <= p1_v_reg;
            p3_v_reg     <= p2_v_reg;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X: org_x_reg <= $signed(cfg_data);
                    CFG_ORIGIN_Y: org_y_reg <= $signed(cfg_data);
                    CFG_ORIGIN_Z: org_z_reg <= $signed(cfg_data);
                    CFG_INV_X:    inv_x_reg <= cfg_data[23:0];
                    CFG_INV_Y:    inv_y_reg <= cfg_data[23:0];
                    CFG_INV_Z:    inv_z_reg <= cfg_data[23:0];
                    CFG_SCALE:    scale_reg <= cfg_data[23:0];
                    CFG_REDUCED:  red_reg   <= cfg_data[2:0];
                    default:      red_reg   <= red_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pz_reg     <= pos_z;
            charge_reg <= charge;
            weight_reg <= weight;
            rplane_reg <= read_plane;
            rx_reg     <= read_x;
            ry_reg     <= read_y;
            rz_reg     <= read_z;
        end
        if ((state_reg == ST_SETUP) && (cnt_reg == 2'd0))
        begin
            qw_reg <= qw;
            if (charge_reg[15])
            begin
                plane_reg <= PLANE_ELEC;
            end
            else if (charge_reg == 16'sd0)
            begin
                plane_reg <= PLANE_NEUT;
            end
            else
            begin
                plane_reg <= PLANE_ION;
            end
        end
        if ((state_reg == ST_SETUP) && (cnt_reg == 2'd1))
        begin
            fnq_reg <= fnq_full[57:16];
        end
        if (ax_res.valid)
        begin
            case (ax_res.tag)
                AXIS_X:
                begin
                    jx_reg  <= ax_res.cpos;
                    wxm_reg <= ax_res.wm;
                    wx0_reg <= ax_res.w0;
                    wxp_reg <= ax_res.wp;
                end
                AXIS_Y:
                begin
                    jy_reg  <= ax_res.cpos;
                    wym_reg <= ax_res.wm;
                    wy0_reg <= ax_res.w0;
                    wyp_reg <= ax_res.wp;
                end
                default:
                begin
                    jz_reg  <= ax_res.cpos;
                    wzm_reg <= ax_res.wm;
                    wz0_reg <= ax_res.w0;
                    wzp_reg <= ax_res.wp;
                end
            endcase
        end
        p1_addr_reg    <= cell_a;
        p1_wxy_reg     <= m1[33:16];
        p1_wz_reg      <= wsel(kz_reg, wzm_reg, wz0_reg, wzp_reg);
        p2_addr_reg    <= p1_addr_reg;
        p2_wxyz_reg    <= m2[34:16];
        p2_old_reg     <= $signed(ram_rdata);
        p3_addr_reg    <= p2_addr_reg;
        p3_contrib_reg <= m3[61:16];
        p3_old_reg     <= p2_old_reg;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cell_value = value_reg;
    assign dropped    = drop_reg;
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor answered");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        p3_v_reg |-> ((state_reg == ST_CELL) || (state_reg == ST_DRAIN)))
        else $error("accumulate write outside deposit");

    a_clear_no_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!p1_v_reg && !p2_v_reg && !p3_v_reg))
        else $error("deposit pipe active during clear");
`endif

endmodule
